// ===== src/jsu_pkg.sv =====
`timescale 1ns / 1ps

package jsu_pkg;

  // Default widths and depths handed to the top level.
  localparam int unsigned LOC_WIDTH_DEF   = 16;
  localparam int unsigned QUEUE_DEPTH_DEF = 4;

  // Width of the location fields on the result ports.
  localparam int unsigned LOC_OUT_W = 16;
  // Width of a Unicode scalar value.
  localparam int unsigned CP_W      = 21;

  // Result kinds.
  localparam logic [1:0] KIND_BYTE  = 2'd0;
  localparam logic [1:0] KIND_DONE  = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  // Error codes.
  localparam logic [3:0] ERR_EXPECTED_STRING = 4'd0;
  localparam logic [3:0] ERR_CONTROL_CHAR    = 4'd1;
  localparam logic [3:0] ERR_EOF_ESCAPE      = 4'd2;
  localparam logic [3:0] ERR_EOF_HEX         = 4'd3;
  localparam logic [3:0] ERR_BAD_HEX         = 4'd4;
  localparam logic [3:0] ERR_NO_BACKSLASH    = 4'd5;
  localparam logic [3:0] ERR_NO_U            = 4'd6;
  localparam logic [3:0] ERR_BAD_LOW         = 4'd7;
  localparam logic [3:0] ERR_LONE_LOW        = 4'd8;
  localparam logic [3:0] ERR_BAD_ESCAPE      = 4'd9;
  localparam logic [3:0] ERR_UNTERMINATED    = 4'd10;

  // Operations passed from the decoder to the output sequencer.
  typedef enum logic [1:0] {
    OP_BYTE,
    OP_CODEPOINT,
    OP_DONE,
    OP_ERROR
  } op_e;

  typedef struct packed {
    op_e                  op;
    logic [CP_W-1:0]      data;
    logic [3:0]           code;
    logic [LOC_OUT_W-1:0] line;
    logic [LOC_OUT_W-1:0] col;
  } cmd_t;

endpackage

// ===== src/json_string_unescape_utf8_unit.sv =====
`timescale 1ns / 1ps

// Channel  | Ports                                          | Handshake
// -------- | ---------------------------------------------- | ----------------------
// input    | in_byte_i, end_of_input_i                      | push / full
// result   | kind_o, out_byte_o, error_code_o, err_line_o,  | empty / pop
//          | err_col_o, last_o                              |
//
// One input word is taken every cycle while the command queue has room; the
// decoder handles it in that cycle, and any command it makes is registered into the queue.
// A \u escape produces one command that leaves as one to four result words, one
// per cycle while pop is held at the sequencer; every other command leaves as a single word.
// full depends only on the queue fill, so a stalled consumer backs up the
// queue before the input side stops. Reset clears decoder state and empties
// the queue.

module json_string_unescape_utf8_unit #(
  parameter int unsigned LOC_WIDTH   = jsu_pkg::LOC_WIDTH_DEF,
  parameter int unsigned QUEUE_DEPTH = jsu_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push,
  output logic                          full,
  input  logic [7:0]                    in_byte_i,
  input  logic                          end_of_input_i,
  output logic                          empty,
  input  logic                          pop,
  output logic [1:0]                    kind_o,
  output logic [7:0]                    out_byte_o,
  output logic [3:0]                    error_code_o,
  output logic [jsu_pkg::LOC_OUT_W-1:0] err_line_o,
  output logic [jsu_pkg::LOC_OUT_W-1:0] err_col_o,
  output logic                          last_o
);

  logic          accept;
  logic          cmd_valid;
  jsu_pkg::cmd_t cmd_in, cmd_head;
  logic          cmd_done;

  // A word is accepted whenever the queue can hold whatever it produces.
  assign accept = push && !full;

  // The decoder tracks the string mode and the location, and turns each
  // word into at most one command for the queue.
  jsu_front #(
    .LOC_WIDTH(LOC_WIDTH)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .valid_i        (accept),
    .in_byte_i      (in_byte_i),
    .end_of_input_i (end_of_input_i),
    .cmd_valid_o    (cmd_valid),
    .cmd_o          (cmd_in)
  );

  // The queue decouples decoding from the multi-word UTF-8 output.
  jsu_fifo #(
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (cmd_valid),
    .wdata_i (cmd_in),
    .rd_i    (cmd_done),
    .rdata_o (cmd_head),
    .full_o  (full),
    .empty_o (empty)
  );

  // The sequencer walks the head command one result word at a time and
  // retires it on its final word.
  jsu_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_valid_i  (!empty),
    .cmd_i        (cmd_head),
    .pop_i        (pop),
    .cmd_done_o   (cmd_done),
    .kind_o       (kind_o),
    .out_byte_o   (out_byte_o),
    .error_code_o (error_code_o),
    .err_line_o   (err_line_o),
    .err_col_o    (err_col_o),
    .last_o       (last_o)
  );

  // The queue can never report full and empty together.
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(full && empty))
    else $error("queue reports full and empty at once");

  // Completion and error results are always single words.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && kind_o != jsu_pkg::KIND_BYTE) |-> last_o)
    else $error("multi-word result that is not a decoded byte");

  // The queue only fills up as a result of an accepted word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(full) |-> $past(push))
    else $error("queue filled without an accepted word");

  // The queue only drains after the consumer took a final word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(empty) |-> ($past(pop) && $past(last_o)))
    else $error("queue drained without a final word popped");

endmodule

// ===== src/jsu_front.sv =====
`timescale 1ns / 1ps

module jsu_front #(
  parameter int unsigned LOC_WIDTH = jsu_pkg::LOC_WIDTH_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  logic [7:0]    in_byte_i,
  input  logic          end_of_input_i,
  output logic          cmd_valid_o,
  output jsu_pkg::cmd_t cmd_o
);

  typedef enum logic [3:0] {
    MODE_WAIT,
    MODE_BODY,
    MODE_ESC,
    MODE_HEX1,
    MODE_PAIR_BS,
    MODE_PAIR_U,
    MODE_HEX2,
    MODE_DONE,
    MODE_ERR
  } mode_e;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CH_F     = 8'h66;
  localparam logic [7:0] CH_N     = 8'h6E;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_U     = 8'h75;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_FF    = 8'h0C;

  // Top six bits of a high and of a low surrogate.
  localparam logic [5:0] SURR_HIGH = 6'b110110;
  localparam logic [5:0] SURR_LOW  = 6'b110111;
  localparam logic [jsu_pkg::CP_W-1:0] SUPP_BASE = 21'h10000;

  localparam logic [LOC_WIDTH-1:0] LOC_MAX = {LOC_WIDTH{1'b1}};
  localparam logic [LOC_WIDTH-1:0] LOC_ONE = LOC_WIDTH'(1);

  mode_e                mode_q, mode_d;
  logic [11:0]          acc_q, acc_d;
  logic [1:0]           digits_q, digits_d;
  logic [9:0]           hs_q, hs_d;
  logic [LOC_WIDTH-1:0] line_q, line_d, col_q, col_d;
  logic [LOC_WIDTH-1:0] sline_q, sline_d, scol_q, scol_d;

  logic [LOC_WIDTH-1:0] adv_line, adv_col;
  logic                 hex_ok;
  logic [3:0]           hex_val;
  logic [15:0]          unit;
  logic                 err;
  logic [3:0]           err_code;
  logic [LOC_WIDTH-1:0] err_line, err_col;

  // Location after consuming the current byte, saturating.
  always_comb begin
    adv_line = line_q;
    adv_col  = col_q;
    if (in_byte_i == CH_LF) begin
      if (line_q != LOC_MAX) begin
        adv_line = line_q + LOC_ONE;
      end
      adv_col = LOC_ONE;
    end else if (col_q != LOC_MAX) begin
      adv_col = col_q + LOC_ONE;
    end
  end

  always_comb begin
    hex_ok  = 1'b1;
    hex_val = 4'd0;
    if (in_byte_i >= 8'h30 && in_byte_i <= 8'h39) begin
      hex_val = in_byte_i[3:0];
    end else if ((in_byte_i >= 8'h61 && in_byte_i <= 8'h66) ||
                 (in_byte_i >= 8'h41 && in_byte_i <= 8'h46)) begin
      hex_val = in_byte_i[3:0] + 4'd9;
    end else begin
      hex_ok = 1'b0;
    end
  end

  assign unit = {acc_q, hex_val};

  always_comb begin
    mode_d   = mode_q;
    acc_d    = acc_q;
    digits_d = digits_q;
    hs_d     = hs_q;
    line_d   = line_q;
    col_d    = col_q;
    sline_d  = sline_q;
    scol_d   = scol_q;
    err      = 1'b0;
    err_code = jsu_pkg::ERR_EXPECTED_STRING;
    err_line = line_q;
    err_col  = col_q;
    cmd_valid_o = 1'b0;
    cmd_o = '{op: jsu_pkg::OP_BYTE, data: '0, code: '0, line: '0, col: '0};

    if (valid_i && end_of_input_i) begin
      unique case (mode_q)
        MODE_WAIT: begin
          err = 1'b1;
          err_code = jsu_pkg::ERR_EXPECTED_STRING;
        end
        MODE_BODY: begin
          err = 1'b1;
          err_code = jsu_pkg::ERR_UNTERMINATED;
        end
        MODE_ESC: begin
          err = 1'b1;
          err_code = jsu_pkg::ERR_EOF_ESCAPE;
        end
        MODE_HEX1, MODE_HEX2: begin
          err = 1'b1;
          err_code = jsu_pkg::ERR_EOF_HEX;
        end
        MODE_PAIR_BS: begin
          err = 1'b1;
          err_code = jsu_pkg::ERR_NO_BACKSLASH;
        end
        MODE_PAIR_U: begin
          err = 1'b1;
          err_code = jsu_pkg::ERR_NO_U;
        end
        default: begin
        end
      endcase
    end else if (valid_i) begin
      unique case (mode_q)
        MODE_WAIT: begin
          if (in_byte_i == CH_SPACE || in_byte_i == CH_TAB ||
              in_byte_i == CH_CR || in_byte_i == CH_LF) begin
            line_d = adv_line;
            col_d  = adv_col;
          end else if (in_byte_i == CH_QUOTE) begin
            line_d = adv_line;
            col_d  = adv_col;
            mode_d = MODE_BODY;
          end else begin
            err = 1'b1;
            err_code = jsu_pkg::ERR_EXPECTED_STRING;
          end
        end
        MODE_BODY: begin
          if (in_byte_i == CH_QUOTE) begin
            line_d = adv_line;
            col_d  = adv_col;
            cmd_valid_o = 1'b1;
            cmd_o.op = jsu_pkg::OP_DONE;
            mode_d = MODE_DONE;
          end else if (in_byte_i < CH_SPACE) begin
            err = 1'b1;
            err_code = jsu_pkg::ERR_CONTROL_CHAR;
          end else if (in_byte_i == CH_BSL) begin
            line_d = adv_line;
            col_d  = adv_col;
            mode_d = MODE_ESC;
          end else begin
            line_d = adv_line;
            col_d  = adv_col;
            cmd_valid_o = 1'b1;
            cmd_o.data = jsu_pkg::CP_W'(in_byte_i);
          end
        end
        MODE_ESC: begin
          line_d = adv_line;
          col_d  = adv_col;
          mode_d = MODE_BODY;
          cmd_valid_o = 1'b1;
          unique case (in_byte_i)
            CH_QUOTE, CH_BSL, CH_SLASH: cmd_o.data = jsu_pkg::CP_W'(in_byte_i);
            CH_B: cmd_o.data = jsu_pkg::CP_W'(CH_BS);
            CH_F: cmd_o.data = jsu_pkg::CP_W'(CH_FF);
            CH_N: cmd_o.data = jsu_pkg::CP_W'(CH_LF);
            CH_R: cmd_o.data = jsu_pkg::CP_W'(CH_CR);
            CH_T: cmd_o.data = jsu_pkg::CP_W'(CH_TAB);
            CH_U: begin
              cmd_valid_o = 1'b0;
              acc_d    = '0;
              digits_d = '0;
              mode_d   = MODE_HEX1;
            end
            default: begin
              // The escape text counts toward the reported location.
              cmd_valid_o = 1'b0;
              err = 1'b1;
              err_code = jsu_pkg::ERR_BAD_ESCAPE;
              err_line = adv_line;
              err_col  = adv_col;
            end
          endcase
        end
        MODE_HEX1, MODE_HEX2: begin
          if (!hex_ok) begin
            err = 1'b1;
            err_code = jsu_pkg::ERR_BAD_HEX;
          end else begin
            line_d = adv_line;
            col_d  = adv_col;
            acc_d  = unit[11:0];
            if (digits_q != 2'd3) begin
              digits_d = digits_q + 2'd1;
            end else begin
              digits_d = '0;
              if (mode_q == MODE_HEX1) begin
                if (unit[15:10] == SURR_HIGH) begin
                  hs_d    = unit[9:0];
                  sline_d = adv_line;
                  scol_d  = adv_col;
                  mode_d  = MODE_PAIR_BS;
                end else if (unit[15:10] == SURR_LOW) begin
                  err = 1'b1;
                  err_code = jsu_pkg::ERR_LONE_LOW;
                  err_line = adv_line;
                  err_col  = adv_col;
                end else begin
                  cmd_valid_o = 1'b1;
                  cmd_o.op   = jsu_pkg::OP_CODEPOINT;
                  cmd_o.data = jsu_pkg::CP_W'(unit);
                  mode_d = MODE_BODY;
                end
              end else begin
                if (unit[15:10] != SURR_LOW) begin
                  // Location goes back to just after the high surrogate.
                  line_d = sline_q;
                  col_d  = scol_q;
                  err = 1'b1;
                  err_code = jsu_pkg::ERR_BAD_LOW;
                  err_line = sline_q;
                  err_col  = scol_q;
                end else begin
                  cmd_valid_o = 1'b1;
                  cmd_o.op   = jsu_pkg::OP_CODEPOINT;
                  cmd_o.data = SUPP_BASE + jsu_pkg::CP_W'({hs_q, unit[9:0]});
                  mode_d = MODE_BODY;
                end
              end
            end
          end
        end
        MODE_PAIR_BS: begin
          if (in_byte_i == CH_BSL) begin
            line_d = adv_line;
            col_d  = adv_col;
            mode_d = MODE_PAIR_U;
          end else begin
            err = 1'b1;
            err_code = jsu_pkg::ERR_NO_BACKSLASH;
          end
        end
        MODE_PAIR_U: begin
          if (in_byte_i == CH_U) begin
            line_d   = adv_line;
            col_d    = adv_col;
            acc_d    = '0;
            digits_d = '0;
            mode_d   = MODE_HEX2;
          end else begin
            err = 1'b1;
            err_code = jsu_pkg::ERR_NO_U;
          end
        end
        default: begin
        end
      endcase
    end

    if (err) begin
      cmd_valid_o = 1'b1;
      cmd_o.op   = jsu_pkg::OP_ERROR;
      cmd_o.data = '0;
      cmd_o.code = err_code;
      cmd_o.line = jsu_pkg::LOC_OUT_W'(err_line);
      cmd_o.col  = jsu_pkg::LOC_OUT_W'(err_col);
      mode_d = MODE_ERR;
    end

    // End of text returns everything to the reset state.
    if (valid_i && end_of_input_i) begin
      mode_d   = MODE_WAIT;
      acc_d    = '0;
      digits_d = '0;
      hs_d     = '0;
      line_d   = LOC_ONE;
      col_d    = LOC_ONE;
      sline_d  = LOC_ONE;
      scol_d   = LOC_ONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_WAIT;
      acc_q    <= '0;
      digits_q <= '0;
      hs_q     <= '0;
      line_q   <= LOC_ONE;
      col_q    <= LOC_ONE;
      sline_q  <= LOC_ONE;
      scol_q   <= LOC_ONE;
    end else begin
      mode_q   <= mode_d;
      acc_q    <= acc_d;
      digits_q <= digits_d;
      hs_q     <= hs_d;
      line_q   <= line_d;
      col_q    <= col_d;
      sline_q  <= sline_d;
      scol_q   <= scol_d;
    end
  end

endmodule

// ===== src/jsu_fifo.sv =====
`timescale 1ns / 1ps

module jsu_fifo #(
  parameter int unsigned DEPTH = jsu_pkg::QUEUE_DEPTH_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_i,
  input  jsu_pkg::cmd_t wdata_i,
  input  logic          rd_i,
  output jsu_pkg::cmd_t rdata_o,
  output logic          full_o,
  output logic          empty_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  jsu_pkg::cmd_t    mem_q [DEPTH];
  logic [PTR_W-1:0] wptr_q, rptr_q;
  logic [CNT_W-1:0] cnt_q;
  logic             do_wr, do_rd;

  assign full_o  = (cnt_q == CNT_FULL);
  assign empty_o = (cnt_q == '0);
  assign do_wr   = wr_i && !full_o;
  assign do_rd   = rd_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_wr) begin
        wptr_q <= (wptr_q == PTR_LAST) ? '0 : wptr_q + PTR_W'(1);
      end
      if (do_rd) begin
        rptr_q <= (rptr_q == PTR_LAST) ? '0 : rptr_q + PTR_W'(1);
      end
      if (do_wr && !do_rd) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (do_rd && !do_wr) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

endmodule

// ===== src/jsu_back.sv =====
`timescale 1ns / 1ps

module jsu_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cmd_valid_i,
  input  jsu_pkg::cmd_t                 cmd_i,
  input  logic                          pop_i,
  output logic                          cmd_done_o,
  output logic [1:0]                    kind_o,
  output logic [7:0]                    out_byte_o,
  output logic [3:0]                    error_code_o,
  output logic [jsu_pkg::LOC_OUT_W-1:0] err_line_o,
  output logic [jsu_pkg::LOC_OUT_W-1:0] err_col_o,
  output logic                          last_o
);

  logic [1:0]                idx_q;
  logic [1:0]                nlast;
  logic [1:0]                pos;
  logic [5:0]                grp;
  logic [jsu_pkg::CP_W-1:0]  d;

  assign d = cmd_i.data;

  // Index of the final UTF-8 byte for this command.
  always_comb begin
    nlast = 2'd0;
    if (cmd_i.op == jsu_pkg::OP_CODEPOINT) begin
      if (d[20:7] == '0) begin
        nlast = 2'd0;
      end else if (d[20:11] == '0) begin
        nlast = 2'd1;
      end else if (d[20:16] == '0) begin
        nlast = 2'd2;
      end else begin
        nlast = 2'd3;
      end
    end
  end

  assign pos = nlast - idx_q;

  always_comb begin
    unique case (pos)
      2'd0:    grp = d[5:0];
      2'd1:    grp = d[11:6];
      default: grp = d[17:12];
    endcase
  end

  always_comb begin
    kind_o       = jsu_pkg::KIND_BYTE;
    out_byte_o   = '0;
    error_code_o = '0;
    err_line_o   = '0;
    err_col_o    = '0;
    unique case (cmd_i.op)
      jsu_pkg::OP_BYTE: out_byte_o = d[7:0];
      jsu_pkg::OP_CODEPOINT: begin
        if (idx_q == 2'd0) begin
          unique case (nlast)
            2'd0: out_byte_o = d[7:0];
            2'd1: out_byte_o = {3'b110, d[10:6]};
            2'd2: out_byte_o = {4'b1110, d[15:12]};
            default: out_byte_o = {5'b11110, d[20:18]};
          endcase
        end else begin
          out_byte_o = {2'b10, grp};
        end
      end
      jsu_pkg::OP_DONE: kind_o = jsu_pkg::KIND_DONE;
      default: begin
        kind_o       = jsu_pkg::KIND_ERROR;
        error_code_o = cmd_i.code;
        err_line_o   = cmd_i.line;
        err_col_o    = cmd_i.col;
      end
    endcase
  end

  assign last_o     = (idx_q == nlast);
  assign cmd_done_o = cmd_valid_i && pop_i && last_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (cmd_valid_i && pop_i) begin
      idx_q <= last_o ? 2'd0 : idx_q + 2'd1;
    end
  end

endmodule
